>>> src/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg
// shared types and constants for the nearest center assignment block
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int MAX_CENTERS = 32;
  localparam int COORD_BITS  = 16;
  localparam int COUNT_BITS  = 24;
  localparam int REQ_W       = 2;
  localparam int IDX_W       = 5;
  localparam int NUM_W       = 6;
  localparam int DIST_W      = 2 * COORD_BITS + 1;
  localparam int SQ_W        = 2 * COORD_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [DIST_W-1:0]            dist_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_CLASSIFY = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  // tag that travels with each center through the distance pipeline
  typedef struct packed {
    logic vld;
    logic last;
    idx_t idx;
  } nca_tag_t;

  // running winner of a scan
  typedef struct packed {
    logic  done;
    idx_t  idx;
    dist_t dist_sq;
  } nca_best_t;

endpackage

>>> src/nca_req_if.sv
// ----------------------------------------------------------------------------
// nca_req_if
// request channel: valid/ready handshake with one request word
// ----------------------------------------------------------------------------
interface nca_req_if;
  import nca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [IDX_W-1:0]      center_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, req_type, center_index, coord_x, coord_y, input ready);
  modport sink   (input valid, req_type, center_index, coord_x, coord_y, output ready);
endinterface

>>> src/nca_res_if.sv
// ----------------------------------------------------------------------------
// nca_res_if
// result channel: valid/ready handshake with one result word
// ----------------------------------------------------------------------------
interface nca_res_if;
  import nca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      assigned_index;
  logic [DIST_W-1:0]     distance_sq;
  logic [COUNT_BITS-1:0] center_count;

  modport source (output valid, assigned_index, distance_sq, center_count, input ready);
  modport sink   (input valid, assigned_index, distance_sq, center_count, output ready);
endinterface

>>> src/nca_ram.sv
// ----------------------------------------------------------------------------
// nca_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/nca_dist_unit.sv
// ----------------------------------------------------------------------------
// nca_dist_unit
// shared squared distance and compare unit, three stages: subtract, square,
// sum and keep the strictly smaller distance
// ----------------------------------------------------------------------------
module nca_dist_unit import nca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  nca_tag_t  tag_i,
  input  coord_t    px_i,
  input  coord_t    py_i,
  input  coord_t    cx_i,
  input  coord_t    cy_i,
  output nca_best_t best_o
);

  nca_tag_t                    s1_tag_q, s2_tag_q;
  logic signed [COORD_BITS:0]  dx_d, dy_d, dx_q, dy_q;
  logic signed [2*COORD_BITS+1:0] px2, py2;
  logic [SQ_W-1:0]             sqx_q, sqy_q;
  dist_t                       sum;
  logic                        upd;
  logic                        done_q;
  idx_t                        best_idx_q;
  dist_t                       best_dist_q;

  assign dx_d = $signed({px_i[COORD_BITS-1], px_i}) - $signed({cx_i[COORD_BITS-1], cx_i});
  assign dy_d = $signed({py_i[COORD_BITS-1], py_i}) - $signed({cy_i[COORD_BITS-1], cy_i});

  assign px2 = dx_q * dx_q;
  assign py2 = dy_q * dy_q;

  assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign upd = s2_tag_q.vld && ((s2_tag_q.idx == '0) || (sum < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      done_q   <= 1'b0;
    end else begin
      s1_tag_q <= tag_i;
      s2_tag_q <= s1_tag_q;
      done_q   <= s2_tag_q.vld && s2_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= px2[SQ_W-1:0];
    sqy_q <= py2[SQ_W-1:0];
    if (upd) begin
      best_idx_q  <= s2_tag_q.idx;
      best_dist_q <= sum;
    end
  end

  assign best_o.done    = done_q;
  assign best_o.idx     = best_idx_q;
  assign best_o.dist_sq = best_dist_q;

`ifndef NO_ASSERTIONS
  // the first center of a scan always opens a fresh winner
  a_first_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_tag_q.vld && s2_tag_q.idx == '0) |=> (best_idx_q == '0))
    else $error("first center did not take the winner slot");
`endif

endmodule

>>> src/nearest_center_assign.sv
// ----------------------------------------------------------------------------
// nearest_center_assign
// nearest center assignment over a table of 2-d centers with hit counts;
// loads centers, classifies points, reads counts
// ----------------------------------------------------------------------------
//   channel  | dir | word
//   req_i    | in  | req_type, center_index, coord_x, coord_y
//   res_o    | out | assigned_index, distance_sq, center_count
//   cfg      | in  | cfg_we_i, cfg_wdata_i (num_centers)
//
// classify: one center per cycle through the shared distance unit, then a
//   read-modify-write of the hit count
// load, unknown: straight to result; query: count read, then result
// one request at a time; req_i.ready is high only when the sequencer is idle
// the output register lets the next request enter while a result waits
// ----------------------------------------------------------------------------
module nearest_center_assign import nca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [NUM_W-1:0] cfg_wdata_i,
  nca_req_if.sink          req_i,
  nca_res_if.source        res_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_CNT_RD = 5'b01000,
    S_RES    = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [NUM_W-1:0]   num_centers_q;
  logic [NUM_W-1:0]   n_eff;
  idx_t               last_idx;
  req_e               req_in;
  logic               accept;
  logic               in_range;

  req_e               req_q, req_d;
  logic               range_q, range_d;
  coord_t             px_q, py_q, px_d, py_d;
  idx_t               k_q, k_d, last_q, last_d;
  idx_t               res_idx_q, res_idx_d;
  dist_t              res_dist_q, res_dist_d;
  count_t             res_cnt_q, res_cnt_d;

  logic               out_vld_q;
  idx_t               out_idx_q;
  dist_t              out_dist_q;
  count_t             out_cnt_q;
  logic               out_load;

  logic [MAX_CENTERS-1:0] cvalid_q, kvalid_q;
  logic               cv_rd_q, kv_rd_q;
  nca_tag_t           tag_q;

  logic               c_we;
  logic [2*COORD_BITS-1:0] c_rdata;
  coord_t             cx, cy;

  logic               k_we;
  idx_t               k_waddr, k_raddr;
  count_t             k_wdata, k_rdata;
  count_t             cnt_cur, cnt_next;

  nca_best_t          best;

  // effective center count: zero acts as one, clipped to the table size
  always_comb begin
    n_eff = num_centers_q;
    if (num_centers_q == '0) begin
      n_eff = NUM_W'(1);
    end else if (num_centers_q > NUM_W'(MAX_CENTERS)) begin
      n_eff = NUM_W'(MAX_CENTERS);
    end
  end
  assign last_idx = IDX_W'(n_eff - NUM_W'(1));

  assign req_in   = req_e'(req_i.req_type);
  assign req_i.ready = (state_q == S_IDLE);
  assign accept   = req_i.valid && req_i.ready;
  assign in_range = ({1'b0, req_i.center_index} < NUM_W'(MAX_CENTERS));

  // center table
  assign c_we = accept && (req_in == REQ_LOAD) && in_range;

  nca_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_CENTERS)) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (req_i.center_index),
    .wdata_i ({req_i.coord_x, req_i.coord_y}),
    .raddr_i (k_q),
    .rdata_o (c_rdata)
  );

  assign cx = cv_rd_q ? coord_t'(c_rdata[2*COORD_BITS-1:COORD_BITS]) : '0;
  assign cy = cv_rd_q ? coord_t'(c_rdata[COORD_BITS-1:0]) : '0;

  nca_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .cx_i   (cx),
    .cy_i   (cy),
    .best_o (best)
  );

  // hit count table
  assign k_we    = c_we || ((state_q == S_CNT_RD) && (req_q == REQ_CLASSIFY));
  assign k_waddr = (state_q == S_CNT_RD) ? res_idx_q : req_i.center_index;
  assign k_wdata = (state_q == S_CNT_RD) ? cnt_next : '0;
  assign k_raddr = (state_q == S_IDLE) ? req_i.center_index : best.idx;

  nca_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CENTERS)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  assign cnt_cur  = kv_rd_q ? k_rdata : '0;
  assign cnt_next = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  assign out_load = (state_q == S_RES) && (!out_vld_q || res_o.ready);

  // sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    range_d    = range_q;
    px_d       = px_q;
    py_d       = py_q;
    k_d        = k_q;
    last_d     = last_q;
    res_idx_d  = res_idx_q;
    res_dist_d = res_dist_q;
    res_cnt_d  = res_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d      = req_in;
          range_d    = in_range;
          px_d       = req_i.coord_x;
          py_d       = req_i.coord_y;
          k_d        = '0;
          last_d     = last_idx;
          res_idx_d  = req_i.center_index;
          res_dist_d = '0;
          res_cnt_d  = '0;
          case (req_in)
            REQ_CLASSIFY: state_d = S_SCAN;
            REQ_QUERY:    state_d = S_CNT_RD;
            default:      state_d = S_RES;
          endcase
        end
      end
      S_SCAN: begin
        k_d = k_q + IDX_W'(1);
        if (k_q == last_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (best.done) begin
          res_idx_d  = best.idx;
          res_dist_d = best.dist_sq;
          state_d    = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        if (req_q == REQ_CLASSIFY) begin
          res_cnt_d = cnt_next;
        end else begin
          res_cnt_d = range_q ? cnt_cur : '0;
        end
        state_d = S_RES;
      end
      S_RES: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      num_centers_q <= NUM_W'(1);
      cvalid_q      <= '0;
      kvalid_q      <= '0;
      tag_q         <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_centers_q <= cfg_wdata_i;
      end
      if (c_we) begin
        cvalid_q[req_i.center_index] <= 1'b1;
      end
      if (k_we) begin
        kvalid_q[k_waddr] <= 1'b1;
      end
      tag_q.vld  <= (state_q == S_SCAN);
      tag_q.last <= (k_q == last_q);
      tag_q.idx  <= k_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    range_q    <= range_d;
    px_q       <= px_d;
    py_q       <= py_d;
    k_q        <= k_d;
    last_q     <= last_d;
    res_idx_q  <= res_idx_d;
    res_dist_q <= res_dist_d;
    res_cnt_q  <= res_cnt_d;
    cv_rd_q    <= cvalid_q[k_q];
    kv_rd_q    <= kvalid_q[k_raddr];
    if (out_load) begin
      out_idx_q  <= res_idx_q;
      out_dist_q <= res_dist_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.assigned_index = out_idx_q;
  assign res_o.distance_sq    = out_dist_q;
  assign res_o.center_count   = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (k_q <= last_q))
    else $error("scan index past last center in use");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best.done |-> (state_q == S_DRAIN))
    else $error("distance unit finished outside drain");

  a_count_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CNT_RD) && (req_q == REQ_CLASSIFY)) |-> (cnt_next != '0))
    else $error("hit count wrapped");

  a_winner_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DRAIN) && best.done) |-> (best.idx <= last_q))
    else $error("winner outside centers in use");
`endif

endmodule

>>> dv/nearest_center_assign_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_center_assign testbench
// Drives load, classify, count and unknown requests through the request
// channel and checks every result word against a local model of the center
// table and hit counts. The run covers several settings of the centers-in-use
// register, including zero and the 6-bit maximum, and random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb;
  import nca_pkg::*;

  typedef struct packed {
    req_e   kind;
    idx_t   slot;
    coord_t x;
    coord_t y;
  } req_word_t;

  typedef struct packed {
    idx_t   idx;
    dist_t  dist_sq;
    count_t cnt;
  } res_word_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [NUM_W-1:0] cfg_wdata_i = '0;

  logic      req_valid = 1'b0;
  req_word_t req_word  = '0;
  logic      res_ready = 1'b0;

  nca_req_if req_if ();
  nca_res_if res_if ();

  assign req_if.valid        = req_valid;
  assign req_if.req_type     = req_word.kind;
  assign req_if.center_index = req_word.slot;
  assign req_if.coord_x      = req_word.x;
  assign req_if.coord_y      = req_word.y;
  assign res_if.ready        = res_ready;

  nearest_center_assign DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  coord_t           center_x [MAX_CENTERS];
  coord_t           center_y [MAX_CENTERS];
  count_t           hits     [MAX_CENTERS];
  logic [NUM_W-1:0] centers_cfg;

  req_word_t pending_words[$];
  res_word_t expected_words[$];
  res_word_t want_word;
  int        send_idle;
  int        recv_idle;
  int        mismatches;

  function automatic int centers_in_use();
    if (centers_cfg == 0) return 1;
    if (centers_cfg > MAX_CENTERS) return MAX_CENTERS;
    return int'(centers_cfg);
  endfunction

  // updates the local table and returns the result word of one request
  function automatic res_word_t serve_request(req_word_t w);
    res_word_t r;
    longint    dx;
    longint    dy;
    longint    d;
    longint    best;
    int        best_k;
    r.idx     = w.slot;
    r.dist_sq = '0;
    r.cnt     = '0;
    case (w.kind)
      REQ_LOAD: begin
        center_x[w.slot] = w.x;
        center_y[w.slot] = w.y;
        hits[w.slot]     = '0;
      end
      REQ_CLASSIFY: begin
        best   = 0;
        best_k = 0;
        for (int k = 0; k < centers_in_use(); k++) begin
          dx = longint'($signed(w.x)) - longint'($signed(center_x[k]));
          dy = longint'($signed(w.y)) - longint'($signed(center_y[k]));
          d  = dx * dx + dy * dy;
          if (k == 0 || d < best) begin
            best   = d;
            best_k = k;
          end
        end
        if (hits[best_k] != COUNT_MAX) hits[best_k] = hits[best_k] + 1'b1;
        r.idx     = idx_t'(best_k);
        r.dist_sq = dist_t'(best);
        r.cnt     = hits[best_k];
      end
      REQ_QUERY: begin
        r.cnt = hits[w.slot];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic coord_t pick_coord(int shape);
    if (shape == 1) begin
      case ($urandom_range(6))
        0: return coord_t'(16'h8000);
        1: return coord_t'(16'h8001);
        2: return coord_t'(16'hFFFF);
        3: return coord_t'(16'h0000);
        4: return coord_t'(16'h0001);
        5: return coord_t'(16'h7FFE);
        default: return coord_t'(16'h7FFF);
      endcase
    end
    if (shape == 2) return coord_t'(int'($urandom_range(8)) - 4);
    return coord_t'($urandom);
  endfunction

  function automatic void queue_word(req_e kind, idx_t slot, coord_t x, coord_t y);
    req_word_t w;
    w.kind = kind;
    w.slot = slot;
    w.x    = x;
    w.y    = y;
    pending_words = {pending_words, w};
  endfunction

  function automatic void queue_random_word(bit load_only, int slot_hint);
    req_e kind;
    int   r;
    int   shape;
    idx_t slot;
    r = $urandom_range(99);
    if (load_only || r < 18) kind = REQ_LOAD;
    else if (r < 75) kind = REQ_CLASSIFY;
    else if (r < 95) kind = REQ_QUERY;
    else kind = REQ_NONE;
    if (slot_hint >= 0) slot = idx_t'(slot_hint);
    else if ($urandom_range(4) != 0) slot = idx_t'($urandom_range(centers_in_use() - 1));
    else slot = idx_t'($urandom);
    r = $urandom_range(9);
    shape = (r < 6) ? 0 : (r < 8) ? 2 : 1;
    queue_word(kind, slot, pick_coord(shape), pick_coord(shape));
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || req_valid || expected_words.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_centers(logic [NUM_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    centers_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_word  <= '0;
    end else begin
      if (req_valid && req_if.ready) begin
        expected_words = {expected_words, serve_request(req_word)};
      end
      if (!req_valid || req_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          req_valid <= 1'b1;
          req_word  <= pending_words.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_if.valid && res_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want_word = expected_words.pop_front();
          if (res_if.assigned_index !== want_word.idx) begin
            $error("assigned_index: expected %0d, got %0d", want_word.idx,
                   res_if.assigned_index);
            mismatches++;
          end
          if (res_if.distance_sq !== want_word.dist_sq) begin
            $error("distance_sq: expected %0d, got %0d", want_word.dist_sq,
                   res_if.distance_sq);
            mismatches++;
          end
          if (res_if.center_count !== want_word.cnt) begin
            $error("center_count: expected %0d, got %0d", want_word.cnt,
                   res_if.center_count);
            mismatches++;
          end
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int phase_cfg [9];
    phase_cfg = '{1, 0, 32, 63, 7, 33, 32, 16, 3};
    mismatches  = 0;
    send_idle   = 21;
    recv_idle   = 74;
    centers_cfg = 1;
    for (int k = 0; k < MAX_CENTERS; k++) begin
      center_x[k] = '0;
      center_y[k] = '0;
      hits[k]     = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ties, extremes, count clear, unknown request
    write_centers(6'd32);
    queue_word(REQ_CLASSIFY, 0, -32768, -32768);
    queue_word(REQ_QUERY, 0, 0, 0);
    queue_word(REQ_LOAD, 0, 32767, 32767);
    queue_word(REQ_CLASSIFY, 9, 32767, 32767);
    queue_word(REQ_CLASSIFY, 0, -32768, -32768);
    queue_word(REQ_LOAD, 3, 5, 5);
    queue_word(REQ_LOAD, 7, 5, 5);
    queue_word(REQ_CLASSIFY, 0, 5, 5);
    queue_word(REQ_CLASSIFY, 0, 6, 6);
    queue_word(REQ_QUERY, 3, 0, 0);
    queue_word(REQ_QUERY, 7, -1, -1);
    queue_word(REQ_NONE, 31, 32767, -32768);
    queue_word(REQ_NONE, 0, 0, 0);
    queue_word(REQ_LOAD, 31, -32768, 32767);
    queue_word(REQ_CLASSIFY, 0, -32768, 32767);
    queue_word(REQ_QUERY, 31, 0, 0);
    queue_word(REQ_LOAD, 3, -1, -1);
    queue_word(REQ_QUERY, 3, 0, 0);
    queue_word(REQ_QUERY, 1, 0, 0);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      send_idle = (p < 3) ? 21 : (p < 6) ? 74 : 0;
      recv_idle = (p < 3) ? 74 : (p < 6) ? 21 : 0;
      write_centers(phase_cfg[p][NUM_W-1:0]);
      for (int k = 0; k < centers_in_use(); k++) queue_random_word(1'b1, k);
      for (int i = centers_in_use(); i < 183; i++) queue_random_word(1'b0, -1);
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
